// ===== hw/rtl/sgfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgfr_pkg
// Shared types and constants for the silence gap frame receiver.
// ----------------------------------------------------------------------------
package sgfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;
    localparam int CNT_W            = 8;
    localparam int GAP_W            = 8;
    localparam int IDX_W            = 7;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 8;
    localparam int IN_TDATA_W       = 16;
    localparam int IN_TUSER_W       = 4;
    localparam int OUT_TDATA_W      = 24;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [GAP_W-1:0] READ_GAP_RST  = 8'd5;
    localparam logic [GAP_W-1:0] RESET_GAP_RST = 8'd3;
    localparam logic [GAP_W-1:0] GAP_MAX       = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_GAP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_GAP = 1'b1;

    // input opcodes
    localparam logic [2:0] OP_BYTE  = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_REARM = 3'd2;
    localparam logic [2:0] OP_HOLD  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_BYTE,
        CMD_BYTE_ERR,
        CMD_TICK,
        CMD_REARM,
        CMD_HOLD,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } t_cmd;

endpackage

// ===== hw/rtl/sgfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgfr_front
// Unpacks input transfers and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module sgfr_front (
    input  logic                             i_s_tvalid,
    input  logic [sgfr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [sgfr_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                             i_q_full,
    output logic                             o_s_tready,
    output logic                             o_push,
    output sgfr_pkg::t_cmd                   o_cmd
);

    logic [2:0]                 w_op;
    logic [7:0]                 w_byte;
    logic                       w_err;
    logic [sgfr_pkg::IDX_W-1:0] w_idx;

    assign w_op   = i_s_tuser[2:0];
    assign w_err  = i_s_tuser[3];
    assign w_byte = i_s_tdata[7:0];
    assign w_idx  = i_s_tdata[14:8];

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        o_cmd.data = w_byte;
        o_cmd.idx  = w_idx;
        unique case (w_op)
            sgfr_pkg::OP_BYTE:  o_cmd.kind = w_err ? sgfr_pkg::CMD_BYTE_ERR
                                                   : sgfr_pkg::CMD_BYTE;
            sgfr_pkg::OP_TICK:  o_cmd.kind = sgfr_pkg::CMD_TICK;
            sgfr_pkg::OP_REARM: o_cmd.kind = sgfr_pkg::CMD_REARM;
            sgfr_pkg::OP_HOLD:  o_cmd.kind = sgfr_pkg::CMD_HOLD;
            sgfr_pkg::OP_READ:  o_cmd.kind = sgfr_pkg::CMD_READ;
            default:            o_cmd.kind = sgfr_pkg::CMD_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/sgfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgfr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sgfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sgfr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output sgfr_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (sgfr_pkg::QUEUE_DEPTH > 1) ? $clog2(sgfr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sgfr_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sgfr_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(sgfr_pkg::QUEUE_DEPTH);

    sgfr_pkg::t_cmd   r_q [sgfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/sgfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgfr_back
// Frame state, gap counter, frame buffer and the registered result stage.
// ----------------------------------------------------------------------------
module sgfr_back #(
    parameter int BUFFER_DEPTH = sgfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  sgfr_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    input  logic                              i_cfg_we,
    input  logic [sgfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sgfr_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [sgfr_pkg::CNT_W-1:0] DEPTH_C = sgfr_pkg::CNT_W'(BUFFER_DEPTH);
    localparam int PAD_W = sgfr_pkg::OUT_TDATA_W - 19;

    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_RECV  = 2'd1,
        ST_READY = 2'd2
    } t_frame_state;

    t_frame_state                 r_state, n_state;
    logic [sgfr_pkg::CNT_W-1:0]   r_bc, n_bc;
    logic [sgfr_pkg::GAP_W-1:0]   r_gap, n_gap;
    logic                         r_rx_on, n_rx_on;
    logic [sgfr_pkg::GAP_W-1:0]   r_read_gap;
    logic [sgfr_pkg::GAP_W-1:0]   r_reset_gap;

    logic [7:0]                   r_mem [BUFFER_DEPTH];
    logic [7:0]                   r_rd_data;

    logic                         r_out_valid;
    logic                         r_out_ready;
    logic                         r_out_recv;
    logic                         r_out_rx_on;
    logic [sgfr_pkg::CNT_W-1:0]   r_out_len;

    logic                         w_exec;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic                         w_rd_en;
    logic [sgfr_pkg::CNT_W-1:0]   w_idx_ext;
    logic [sgfr_pkg::GAP_W-1:0]   w_gap_inc;

    assign w_exec    = i_valid && (!r_out_valid || i_m_tready);
    assign o_pop     = w_exec;
    assign w_idx_ext = {1'b0, i_cmd.idx};
    assign w_rd_en   = (i_cmd.kind == sgfr_pkg::CMD_READ) && (w_idx_ext < r_bc)
                       && (w_idx_ext < DEPTH_C);
    // tick count saturates once past read_gap or at the top of the range
    assign w_gap_inc = ((r_gap <= r_read_gap) && (r_gap != sgfr_pkg::GAP_MAX))
                       ? r_gap + 1'b1 : r_gap;

    always_comb begin
        n_state = r_state;
        n_bc    = r_bc;
        n_gap   = r_gap;
        n_rx_on = r_rx_on;
        w_we    = 1'b0;
        w_waddr = r_bc[AW-1:0];
        unique case (i_cmd.kind)
            sgfr_pkg::CMD_BYTE: begin
                if (r_rx_on) begin
                    n_gap = '0;
                    if (r_gap >= r_read_gap) begin
                        // fresh frame: first byte to entry zero
                        w_we    = 1'b1;
                        w_waddr = '0;
                        n_bc    = sgfr_pkg::CNT_W'(1);
                        n_state = ST_RECV;
                    end else if (r_gap < r_reset_gap) begin
                        if (r_bc >= DEPTH_C) begin
                            n_bc    = '0;
                            n_state = ST_WAIT;
                        end else begin
                            w_we    = 1'b1;
                            n_bc    = r_bc + 1'b1;
                            n_state = ST_RECV;
                        end
                    end
                end
            end
            sgfr_pkg::CMD_BYTE_ERR: begin
                if (r_rx_on) begin
                    n_gap   = '0;
                    n_state = ST_WAIT;
                    n_bc    = '0;
                    n_rx_on = 1'b1;
                end
            end
            sgfr_pkg::CMD_TICK: begin
                n_gap = w_gap_inc;
                if ((w_gap_inc >= r_read_gap) && (r_state == ST_RECV)) begin
                    n_rx_on = 1'b0;
                    n_state = ST_READY;
                end
            end
            sgfr_pkg::CMD_REARM: begin
                n_state = ST_WAIT;
                n_bc    = '0;
                n_rx_on = 1'b1;
            end
            sgfr_pkg::CMD_HOLD: begin
                n_state = ST_WAIT;
                n_rx_on = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_bc        <= '0;
            r_gap       <= sgfr_pkg::READ_GAP_RST;
            r_rx_on     <= 1'b0;
            r_read_gap  <= sgfr_pkg::READ_GAP_RST;
            r_reset_gap <= sgfr_pkg::RESET_GAP_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sgfr_pkg::CFG_READ_GAP:  r_read_gap  <= i_cfg_data;
                    sgfr_pkg::CFG_RESET_GAP: r_reset_gap <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_exec) begin
                r_state     <= n_state;
                r_bc        <= n_bc;
                r_gap       <= n_gap;
                r_rx_on     <= n_rx_on;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_ready <= (n_state == ST_READY);
            r_out_recv  <= (n_state == ST_RECV);
            r_out_rx_on <= n_rx_on;
            r_out_len   <= n_bc;
        end
    end

    // frame buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_exec && w_we) begin
            r_mem[w_waddr] <= i_cmd.data;
        end
        if (w_exec) begin
            r_rd_data <= w_rd_en ? r_mem[w_idx_ext[AW-1:0]] : 8'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_rd_data, r_out_rx_on, r_out_recv,
                         r_out_len, r_out_ready};

endmodule

// ===== hw/rtl/silence_gap_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silence_gap_frame_receiver
// Collects UART bytes into a frame buffer and delimits frames by line silence.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  s        | in        | i_s_tvalid/o_s_tready| tdata: rx_byte, read_index
//           |           |                      | tuser: opcode, line_error
//  m        | out       | o_m_tvalid/i_m_tready| frame_ready, frame_length,
//           |           |                      | receiving, receive_enabled,
//           |           |                      | read_data
//  cfg      | in        | i_cfg_we             | register index + 8-bit value
//
//  One transfer per cycle sustained while the output is not stalled: a
//  command is registered in the queue, then executed by the back end with its
//  result registered. The frame buffer read port registers read data
//  alongside the status fields, so read data comes in the same transfer.
//  Reset (synchronous, active low) empties the queue and result stage, sets
//  the gaps to 5 and 3, reception off. Frame buffer contents are not cleared.
//  A stall at the output holds the result; the two-entry queue absorbs the
//  input side, and o_s_tready drops only when it is full.
// ----------------------------------------------------------------------------
module silence_gap_frame_receiver #(
    parameter int BUFFER_DEPTH = sgfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream input
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] rx_byte, [14:8] read_index
    input  logic [sgfr_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [2:0] opcode, [3] line_error
    input  logic [sgfr_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    // stream output
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] frame_ready, [8:1] frame_length, [9] receiving,
    // [10] receive_enabled, [18:11] read_data
    output logic [sgfr_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [sgfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sgfr_pkg::t_cmd w_push_cmd;
    sgfr_pkg::t_cmd w_pop_cmd;
    logic           w_push;
    logic           w_pop;
    logic           w_q_full;
    logic           w_q_valid;

    // front end: classify each incoming transfer
    sgfr_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_s_tready (o_s_tready),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // decoupling queue
    sgfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    // back end: frame state machine, buffer and result register
    sgfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_cmd      (w_pop_cmd),
        .o_pop      (w_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // ready and receiving are exclusive frame states
    a_state_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[9]))
        else $error("frame ready and receiving reported together");

    // a ready frame always has reception stopped
    a_ready_stops_rx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> !o_m_tdata[10])
        else $error("frame ready while reception still enabled");

    // the frame length never exceeds the buffer
    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8:1] <= sgfr_pkg::CNT_W'(BUFFER_DEPTH)))
        else $error("frame length beyond buffer depth");

    // the queue can only refuse input while the back end has work pending
    a_ready_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> w_q_valid)
        else $error("input stalled with an empty queue");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the silence gap frame receiver. Commands go in over
// the slave stream, one status transfer comes back per command. A behavioural
// shadow of the receiver predicts every status transfer. Directed tests come
// first, then random frame traffic under several gap settings and idle mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH       = sgfr_pkg::BUFFER_DEPTH_DEF;
    localparam int BUF_AW      = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 4;

    // opcodes the block treats as no-ops
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_MID_UNUSED   = 3'd6;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    typedef enum logic [1:0] {
        FS_WAIT,
        FS_RECV,
        FS_READY
    } t_frame_state;

    typedef struct packed {
        logic       frame_ready;
        logic [7:0] frame_length;
        logic       receiving;
        logic       receive_enabled;
        logic [7:0] read_data;
    } t_status;

    // DUT drive - all known from time zero
    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic [sgfr_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;
    logic [sgfr_pkg::IN_TUSER_W-1:0]    s_tuser  = '0;
    logic                               m_tready = 1'b0;
    logic                               cfg_we   = 1'b0;
    logic [sgfr_pkg::CFG_IDX_W-1:0]     cfg_idx  = '0;
    logic [sgfr_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    wire                                s_tready;
    wire                                m_tvalid;
    wire [sgfr_pkg::OUT_TDATA_W-1:0]    m_tdata;

    // shadow copy of the receiver state and its gap registers
    logic [7:0]                         shadow_buf [DEPTH];
    logic [sgfr_pkg::GAP_W-1:0]         silence_cnt;
    t_frame_state                       frame_st;
    logic [sgfr_pkg::CNT_W-1:0]         held_bytes;
    logic                               rx_enabled;
    logic [sgfr_pkg::GAP_W-1:0]         read_gap_cfg;
    logic [sgfr_pkg::GAP_W-1:0]         reset_gap_cfg;

    // status words predicted but not yet seen at the master side
    t_status                            pending_status [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int items_sent   = 0;
    int fail_count   = 0;
    int cycle_count  = 0;

    always #5 clk = ~clk;

    silence_gap_frame_receiver uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow receiver
    // ------------------------------------------------------------------------
    function automatic void reset_shadow();
        read_gap_cfg  = sgfr_pkg::READ_GAP_RST;
        reset_gap_cfg = sgfr_pkg::RESET_GAP_RST;
        silence_cnt   = sgfr_pkg::READ_GAP_RST;   // starts out as a long silence
        frame_st      = FS_WAIT;
        held_bytes    = '0;
        rx_enabled    = 1'b0;                     // off until rearmed
        pending_status.delete();
    endfunction

    function automatic void reopen_reception();
        frame_st   = FS_WAIT;
        held_bytes = '0;
        rx_enabled = 1'b1;
    endfunction

    // a full buffer throws the frame away rather than storing
    function automatic void store_rx_byte(input logic [7:0] b);
        if (held_bytes >= DEPTH) begin
            held_bytes = '0;
            frame_st   = FS_WAIT;
        end else begin
            shadow_buf[held_bytes[BUF_AW-1:0]] = b;
            held_bytes = held_bytes + 1'b1;
            frame_st   = FS_RECV;
        end
    endfunction

    function automatic void predict_status(input logic [2:0] op, input logic [7:0] b,
                                           input logic err,
                                           input logic [sgfr_pkg::IDX_W-1:0] idx);
        t_status    st;
        logic [7:0] rd;
        rd = '0;
        case (op)
            sgfr_pkg::OP_BYTE: begin
                // bytes while reception is off leave even the silence count alone
                if (rx_enabled) begin
                    if (err)
                        reopen_reception();
                    else if (silence_cnt >= read_gap_cfg) begin
                        held_bytes = '0;
                        store_rx_byte(b);
                    end else if (silence_cnt < reset_gap_cfg)
                        store_rx_byte(b);
                    // gaps between the two thresholds drop the byte
                    silence_cnt = '0;
                end
            end
            sgfr_pkg::OP_TICK: begin
                if (silence_cnt <= read_gap_cfg && silence_cnt != sgfr_pkg::GAP_MAX)
                    silence_cnt = silence_cnt + 1'b1;
                if (silence_cnt >= read_gap_cfg && frame_st == FS_RECV) begin
                    rx_enabled = 1'b0;
                    frame_st   = FS_READY;
                end
            end
            sgfr_pkg::OP_REARM: reopen_reception();
            sgfr_pkg::OP_HOLD: begin
                rx_enabled = 1'b0;
                frame_st   = FS_WAIT;
            end
            sgfr_pkg::OP_READ: begin
                if ({1'b0, idx} < held_bytes && idx < DEPTH)
                    rd = shadow_buf[idx];
            end
            default: ;
        endcase
        st.frame_ready     = (frame_st == FS_READY);
        st.frame_length    = held_bytes;
        st.receiving       = (frame_st == FS_RECV);
        st.receive_enabled = rx_enabled;
        st.read_data       = rd;
        pending_status.push_back(st);
    endfunction

    // ------------------------------------------------------------------------
    // Master side: random back-pressure and status checking
    // ------------------------------------------------------------------------
    function automatic void check_status(input logic [sgfr_pkg::OUT_TDATA_W-1:0] word);
        t_status got;
        t_status want;
        got.frame_ready     = word[0];
        got.frame_length    = word[8:1];
        got.receiving       = word[9];
        got.receive_enabled = word[10];
        got.read_data       = word[18:11];
        if (pending_status.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $display("status transfer with nothing expected: %h", word);
            fail_count++;
        end else begin
            want = pending_status.pop_front();
            if (got !== want) begin
                if (fail_count < MAX_REPORTS) begin
                    $write("status mismatch: exp rdy=%0d len=%0d rcv=%0d en=%0d dat=%02h",
                           want.frame_ready, want.frame_length, want.receiving,
                           want.receive_enabled, want.read_data);
                    $display(" / got rdy=%0d len=%0d rcv=%0d en=%0d dat=%02h",
                             got.frame_ready, got.frame_length, got.receiving,
                             got.receive_enabled, got.read_data);
                end
                fail_count++;
            end
        end
    endfunction

    // outputs are sampled at the edge before the DUT updates them
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            check_status(m_tdata);
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("silence_gap_frame_receiver test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Slave side
    // ------------------------------------------------------------------------
    // tvalid is left high after a transfer so back-to-back sends never
    // lower and raise it in one step; it only drops on an idle or a drain
    task automatic send_item(input logic [2:0] op, input logic [7:0] b,
                             input logic err, input logic [sgfr_pkg::IDX_W-1:0] idx);
        logic [sgfr_pkg::IN_TDATA_W-1:0] word;
        logic [sgfr_pkg::IN_TUSER_W-1:0] user;
        word       = '0;
        word[7:0]  = b;
        word[14:8] = idx;
        user       = {err, op};
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= user;
        do @(posedge clk); while (!s_tready);
        predict_status(op, b, err, idx);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(sgfr_pkg::OP_BYTE, b, 1'b0, sgfr_pkg::IDX_W'($urandom_range(127)));
    endtask

    task automatic send_cmd(input logic [2:0] op);
        send_item(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  sgfr_pkg::IDX_W'($urandom_range(127)));
    endtask

    task automatic send_read(input logic [sgfr_pkg::IDX_W-1:0] idx);
        send_item(sgfr_pkg::OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), idx);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_cmd(sgfr_pkg::OP_TICK);
    endtask

    // wait until every status transfer is back, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // both gap registers, written on consecutive edges while idle
    task automatic set_gaps(input logic [7:0] rd_gap, input logic [7:0] rs_gap);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= sgfr_pkg::CFG_READ_GAP;
        cfg_data <= rd_gap;
        @(posedge clk);
        cfg_idx  <= sgfr_pkg::CFG_RESET_GAP;
        cfg_data <= rs_gap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        read_gap_cfg  = rd_gap;
        reset_gap_cfg = rs_gap;
    endtask

    // ------------------------------------------------------------------------
    // Gap and index choices relative to the current settings
    // ------------------------------------------------------------------------
    // below both thresholds: byte is appended and the frame stays open
    function automatic int short_gap();
        int lim;
        lim = int'((reset_gap_cfg < read_gap_cfg) ? reset_gap_cfg : read_gap_cfg);
        if (lim > 4 && $urandom_range(7) != 0)
            lim = 4;
        return $urandom_range(lim - 1, 0);
    endfunction

    // between the thresholds: byte is dropped (a short gap if there is no such range)
    function automatic int mid_gap();
        int span;
        if (reset_gap_cfg >= read_gap_cfg)
            return short_gap();
        span = read_gap_cfg - 1 - reset_gap_cfg;
        return reset_gap_cfg + $urandom_range((span > 4) ? 4 : span);
    endfunction

    // at or past read_gap: closes the frame or opens a new one
    function automatic int long_gap();
        return read_gap_cfg + $urandom_range(2);
    endfunction

    function automatic logic [sgfr_pkg::IDX_W-1:0] pick_index();
        if (held_bytes != 0 && $urandom_range(3) != 0)
            return sgfr_pkg::IDX_W'($urandom_range(held_bytes - 1));
        return sgfr_pkg::IDX_W'($urandom_range(127));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // every opcode and the corner cases at the reset gap settings (5 / 3)
    task automatic test_basic_ops();
        send_read(7'd0);                      // status straight after reset
        send_byte(8'hFF);                     // reception still off: ignored
        send_item(OP_FIRST_UNUSED, 8'h00, 1'b1, 7'd127);
        send_cmd(sgfr_pkg::OP_REARM);
        send_cmd(sgfr_pkg::OP_TICK);          // silence 6, above read_gap
        send_byte(8'h00);                     // opens a new frame
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_ticks(2);
        send_byte(8'h5A);                     // gap 2 < reset_gap: appended
        send_ticks(3);
        send_byte(8'h3C);                     // gap 3: dropped
        send_ticks(5);                        // frame marked ready
        send_byte(8'h81);                     // reception stopped: ignored
        send_read(7'd3);
        send_read(7'd4);                      // past the frame: reads 0
        send_read(7'd127);
        send_cmd(sgfr_pkg::OP_HOLD);          // length kept, reception off
        send_read(7'd1);
        send_cmd(sgfr_pkg::OP_REARM);
        send_item(sgfr_pkg::OP_BYTE, 8'h7E, 1'b1, 7'd0); // line error rearms
        send_item(sgfr_pkg::OP_TICK, 8'h00, 1'b1, 7'd0); // error flag ignored on a tick
        send_item(OP_LAST_UNUSED, 8'hFF, 1'b0, 7'd127);
        send_item(OP_MID_UNUSED, 8'h55, 1'b1, 7'd85);
    endtask

    // fill the buffer to the brim, then one byte more
    task automatic test_overflow();
        send_cmd(sgfr_pkg::OP_REARM);
        send_ticks(long_gap());
        repeat (DEPTH) send_byte(8'($urandom_range(255)));
        send_read(sgfr_pkg::IDX_W'(DEPTH - 1));
        send_read(7'd0);
        send_byte(8'($urandom_range(255)));   // overflow: frame emptied
        send_read(7'd0);
        send_byte(8'($urandom_range(255)));   // short gap: first byte again
        send_ticks(long_gap());
        send_read(7'd0);
    endtask

    // read_gap near the top, so the silence count runs into its ceiling
    task automatic test_long_silence();
        set_gaps(8'd254, 8'd254);
        send_cmd(sgfr_pkg::OP_REARM);
        send_byte(8'h12);
        send_ticks(260);
        send_cmd(sgfr_pkg::OP_REARM);
        send_byte(8'hED);                     // silence saturated at its ceiling
        send_read(7'd0);
    endtask

    // one frame: silence, bytes with mostly short gaps, close, read out
    task automatic random_frame();
        int nbytes;
        int roll;
        if (!rx_enabled || frame_st != FS_WAIT || $urandom_range(3) == 0)
            send_cmd(sgfr_pkg::OP_REARM);
        send_ticks(long_gap());
        nbytes = ($urandom_range(15) == 0) ? $urandom_range(DEPTH + 2, DEPTH - 2)
                                           : $urandom_range(12, 1);
        for (int i = 0; i < nbytes; i++) begin
            send_byte(8'($urandom_range(255)));
            if (i < nbytes - 1) begin
                roll = $urandom_range(9);
                if (roll < 8)
                    send_ticks(short_gap());
                else if (roll == 8)
                    send_ticks(mid_gap());
                else
                    send_ticks(long_gap());
            end
        end
        send_ticks(long_gap());
        repeat ($urandom_range(4, 1)) send_read(pick_index());
        if ($urandom_range(7) == 0)
            send_cmd(sgfr_pkg::OP_HOLD);
    endtask

    task automatic random_traffic(input int n);
        int start;
        int roll;
        start = items_sent;
        while (items_sent - start < n) begin
            roll = $urandom_range(99);
            if (roll < 60)
                random_frame();
            else if (roll < 72)
                send_read(pick_index());
            else if (roll < 82)
                send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), sgfr_pkg::IDX_W'($urandom_range(127)));
            else if (roll < 87)
                send_item(sgfr_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b1,
                          sgfr_pkg::IDX_W'($urandom_range(127)));
            else if (roll < 92)
                send_cmd(sgfr_pkg::OP_HOLD);
            else if (roll < 96)
                send_ticks($urandom_range(6));
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic [7:0] rd_gap, input logic [7:0] rs_gap,
                             input int n);
        set_gaps(rd_gap, rs_gap);
        random_traffic(n);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver stalling hard
        src_idle_pct = 18;
        snk_idle_pct = 73;
        test_basic_ops();
        test_overflow();
        run_phase(8'd5, 8'd3, 220);
        run_phase(8'd1, 8'd1, 150);

        // sparse sender, eager receiver
        src_idle_pct = 73;
        snk_idle_pct = 18;
        test_long_silence();
        run_phase(8'd24, 8'd24, 120);
        run_phase(8'd3, 8'd8, 150);

        // full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(8'($urandom_range(20, 1)), 8'($urandom_range(20, 1)), 110);
        run_phase(8'd40, 8'd1, 80);

        wait_drained();
        if (fail_count == 0)
            $display("silence_gap_frame_receiver test passed");
        else
            $display("silence_gap_frame_receiver test failed");
        $finish;
    end

endmodule
